// ===== rtl/core/hsvrgb_pkg.sv =====
package hsvrgb_pkg;

    // Default fraction width of all fixed-point fields
    localparam int FRAC_BITS_DEF = 16;

    // Fixed input field widths
    localparam int HUE_W    = 24;
    localparam int SAT_W    = 18;
    localparam int BRIGHT_W = 18;

    // Hexcone sector index width and queue depth between front and back
    localparam int SECTOR_W    = 3;
    localparam int QUEUE_DEPTH = 2;

    // Hexcone sectors, in order of rising hue
    typedef enum logic [SECTOR_W-1:0] {
        SECT_RED_YELLOW    = 3'd0,
        SECT_YELLOW_GREEN  = 3'd1,
        SECT_GREEN_CYAN    = 3'd2,
        SECT_CYAN_BLUE     = 3'd3,
        SECT_BLUE_MAGENTA  = 3'd4,
        SECT_MAGENTA_RED   = 3'd5
    } sector_t;

    // Queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== rtl/core/hsvrgb_front.sv =====
module hsvrgb_front #(
    parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF,
    parameter int ITEM_W    = 4 * FRAC_BITS + 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [hsvrgb_pkg::HUE_W-1:0]    hue_in,
    input  logic signed [hsvrgb_pkg::SAT_W-1:0]    sat_in,
    input  logic signed [hsvrgb_pkg::BRIGHT_W-1:0] bright_in,
    input  hsvrgb_pkg::q_status_t               q_status,
    output logic                                busy,
    output logic                                push,
    output logic                                front_valid,
    output logic [ITEM_W-1:0]                   item
);
    import hsvrgb_pkg::*;

    localparam int FB = FRAC_BITS;
    localparam int CW = (FB + 2 > SAT_W) ? FB + 2 : SAT_W;
    localparam logic signed [CW-1:0] ONE_C = CW'(longint'(1) << FB);
    localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

    logic                    valid_reg, valid_next;
    logic [ITEM_W-1:0]       item_reg, item_next;
    logic                    advance;
    logic signed [CW-1:0]    s_ext, v_ext;
    logic [FB:0]             s_clamp, v_clamp;
    logic [FB-1:0]           h_wrap;
    logic [FB+2:0]           h6;
    logic                    grey;

    // Clamp saturation and brightness to [0, ONE]
    always_comb
    begin
        s_ext = CW'(sat_in);
        v_ext = CW'(bright_in);
        if (s_ext[CW-1] || s_ext == '0)
            s_clamp = '0;
        else if (s_ext >= ONE_C)
            s_clamp = ONE;
        else
            s_clamp = s_ext[FB:0];
        if (v_ext[CW-1] || v_ext == '0)
            v_clamp = '0;
        else if (v_ext >= ONE_C)
            v_clamp = ONE;
        else
            v_clamp = v_ext[FB:0];
    end

    // Wrap hue to one turn, scale by six and classify
    assign h_wrap = hue_in[FB-1:0];
    assign h6     = {1'b0, h_wrap, 2'b00} + {2'b00, h_wrap, 1'b0};
    assign grey   = (s_clamp == '0);

    // Hold the request while the queue is full
    assign advance     = !valid_reg || !q_status.full;
    assign busy        = !advance;
    assign push        = valid_reg && !q_status.full;
    assign front_valid = valid_reg;
    assign item        = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (advance)
        begin
            valid_next = start;
            if (start)
                item_next = {grey, h6[FB+2:FB], h6[FB-1:0], h_wrap, s_clamp, v_clamp};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// ===== rtl/core/hsvrgb_queue.sv =====
module hsvrgb_queue #(
    parameter int WIDTH = 70,
    parameter int DEPTH = hsvrgb_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  pop,
    output logic [WIDTH-1:0]      rdata,
    output hsvrgb_pkg::q_status_t status
);
    import hsvrgb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNTW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    // Occupancy never exceeds the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(DEPTH))
        else $error("queue occupancy above depth");

    // A pop empties one slot unless a push refills it
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not drop on pop");

endmodule

// ===== rtl/core/hsvrgb_back.sv =====
module hsvrgb_back #(
    parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF,
    parameter int ITEM_W    = 4 * FRAC_BITS + 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hsvrgb_pkg::q_status_t    q_status,
    input  logic [ITEM_W-1:0]        item,
    output logic                     pop,
    output logic                     done,
    output logic [FRAC_BITS:0]       red,
    output logic [FRAC_BITS:0]       green,
    output logic [FRAC_BITS:0]       blue,
    output logic [FRAC_BITS-1:0]     hue_wrapped,
    output logic [FRAC_BITS:0]       sat_clamped,
    output logic [FRAC_BITS:0]       bright_clamped
);
    import hsvrgb_pkg::*;

    localparam int FB = FRAC_BITS;
    localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

    // Unpacked request fields
    logic                 in_grey;
    logic [SECTOR_W-1:0]  in_sector;
    logic [FB-1:0]        in_f, in_h;
    logic [FB:0]          in_s, in_v;

    // Stage 1 registers
    logic                 valid1_reg;
    logic                 grey1_reg;
    logic [SECTOR_W-1:0]  sector1_reg;
    logic [FB-1:0]        h1_reg;
    logic [FB:0]          s1_reg, v1_reg, sf1_reg, sg1_reg, m1_reg;

    // Stage 2 (output) registers
    logic                 done_reg;
    logic [FB:0]          red_reg, green_reg, blue_reg;
    logic [FB-1:0]        hue_reg;
    logic [FB:0]          sat_reg, bright_reg;

    logic [FB:0]          red_next, green_next, blue_next;
    logic [2*FB+1:0]      prod_sf, prod_sg, prod_m, prod_n, prod_k;
    logic [FB:0]          n_val, k_val;

    assign {in_grey, in_sector, in_f, in_h, in_s, in_v} = item;
    assign pop = !q_status.empty;

    // Stage 1: S*F, S*(1-F) and V*(1-S)
    assign prod_sf = in_s * {1'b0, in_f};
    assign prod_sg = in_s * (ONE - {1'b0, in_f});
    assign prod_m  = in_v * (ONE - in_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            valid1_reg <= pop;
            done_reg   <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            grey1_reg   <= in_grey;
            sector1_reg <= in_sector;
            h1_reg      <= in_h;
            s1_reg      <= in_s;
            v1_reg      <= in_v;
            sf1_reg     <= prod_sf[2*FB:FB];
            sg1_reg     <= prod_sg[2*FB:FB];
            m1_reg      <= prod_m[2*FB:FB];
        end
    end

    // Stage 2: V*(1-S*F) and V*(1-S*(1-F)), then route by sector
    assign prod_n = v1_reg * (ONE - sf1_reg);
    assign prod_k = v1_reg * (ONE - sg1_reg);
    assign n_val  = prod_n[2*FB:FB];
    assign k_val  = prod_k[2*FB:FB];

    always_comb
    begin
        red_next   = v1_reg;
        green_next = v1_reg;
        blue_next  = v1_reg;
        if (!grey1_reg)
        begin
            case (sector_t'(sector1_reg))
                SECT_RED_YELLOW:
                begin
                    red_next = v1_reg; green_next = k_val;  blue_next = m1_reg;
                end
                SECT_YELLOW_GREEN:
                begin
                    red_next = n_val;  green_next = v1_reg; blue_next = m1_reg;
                end
                SECT_GREEN_CYAN:
                begin
                    red_next = m1_reg; green_next = v1_reg; blue_next = k_val;
                end
                SECT_CYAN_BLUE:
                begin
                    red_next = m1_reg; green_next = n_val;  blue_next = v1_reg;
                end
                SECT_BLUE_MAGENTA:
                begin
                    red_next = k_val;  green_next = m1_reg; blue_next = v1_reg;
                end
                default:
                begin
                    red_next = v1_reg; green_next = m1_reg; blue_next = n_val;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid1_reg)
        begin
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            hue_reg    <= h1_reg;
            sat_reg    <= s1_reg;
            bright_reg <= v1_reg;
        end
    end

    assign done           = done_reg;
    assign red            = red_reg;
    assign green          = green_reg;
    assign blue           = blue_reg;
    assign hue_wrapped    = hue_reg;
    assign sat_clamped    = sat_reg;
    assign bright_clamped = bright_reg;

endmodule

// ===== rtl/core/hsv_to_rgb_converter_unit.sv =====
// HSV to RGB converter: one request per clock, no state between requests.
// A taken request passes through the queue write, the multiply stage and the route and
// output register, in that order, before done rises.
// Throughput: one request per cycle; the back pops every cycle, so busy stays low.
// The receiver cannot stall: each result shows for one cycle under done.
// Reset (rst_n low, asynchronous) empties the front, queue and pipeline.
module hsv_to_rgb_converter_unit #(
    parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [hsvrgb_pkg::HUE_W-1:0]    hue_in,
    input  logic signed [hsvrgb_pkg::SAT_W-1:0]    sat_in,
    input  logic signed [hsvrgb_pkg::BRIGHT_W-1:0] bright_in,
    output logic                                   done,
    output logic [FRAC_BITS:0]                     red,
    output logic [FRAC_BITS:0]                     green,
    output logic [FRAC_BITS:0]                     blue,
    output logic [FRAC_BITS-1:0]                   hue_wrapped,
    output logic [FRAC_BITS:0]                     sat_clamped,
    output logic [FRAC_BITS:0]                     bright_clamped
);
    import hsvrgb_pkg::*;

    localparam int ITEM_W = 4 * FRAC_BITS + 6;

    q_status_t          q_status;
    logic               push, pop, front_valid;
    logic [ITEM_W-1:0]  front_item, queue_item;

    // Accept, clamp and classify requests
    hsvrgb_front #(
        .FRAC_BITS (FRAC_BITS),
        .ITEM_W    (ITEM_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .hue_in      (hue_in),
        .sat_in      (sat_in),
        .bright_in   (bright_in),
        .q_status    (q_status),
        .busy        (busy),
        .push        (push),
        .front_valid (front_valid),
        .item        (front_item)
    );

    // Decouple front from back
    hsvrgb_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (front_item),
        .pop    (pop),
        .rdata  (queue_item),
        .status (q_status)
    );

    // Multiply and route to RGB
    hsvrgb_back #(
        .FRAC_BITS (FRAC_BITS),
        .ITEM_W    (ITEM_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .item           (queue_item),
        .pop            (pop),
        .done           (done),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .hue_wrapped    (hue_wrapped),
        .sat_clamped    (sat_clamped),
        .bright_clamped (bright_clamped)
    );

    // A taken request is held in the front register next cycle
    a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> front_valid)
        else $error("accepted request lost in front");

    // Every request leaving the queue comes out through the stage 1 and output registers
    a_pop_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> ##2 done)
        else $error("popped request did not produce a result");

    // Busy only while the front holds a request against a full queue
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (front_valid && q_status.full))
        else $error("busy without a blocked request");

    // Zero saturation gives grey at the brightness level
    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (done && sat_clamped == '0) |->
            (red == bright_clamped && green == bright_clamped && blue == bright_clamped))
        else $error("zero saturation did not give grey");

endmodule

// ===== tb/sv/hsv_to_rgb_checker.sv =====
module hsv_to_rgb_checker
    import hsvrgb_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic signed [HUE_W-1:0]     hue_in,
    input  logic signed [SAT_W-1:0]     sat_in,
    input  logic signed [BRIGHT_W-1:0]  bright_in,
    input  logic                        done,
    input  logic [FRAC_BITS_DEF:0]      red,
    input  logic [FRAC_BITS_DEF:0]      green,
    input  logic [FRAC_BITS_DEF:0]      blue,
    input  logic [FRAC_BITS_DEF-1:0]    hue_wrapped,
    input  logic [FRAC_BITS_DEF:0]      sat_clamped,
    input  logic [FRAC_BITS_DEF:0]      bright_clamped,
    output int                          errors,
    output int                          outstanding,
    output int                          pixels_checked,
    output int                          grey_pixels,
    output logic [5:0]                  sectors_hit
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = FRAC_BITS_DEF;
    localparam logic [63:0] ONE = 64'd1 << FB;

    typedef struct packed {
        logic [FB:0]   red;
        logic [FB:0]   green;
        logic [FB:0]   blue;
        logic [FB-1:0] hue;
        logic [FB:0]   sat;
        logic [FB:0]   bright;
        logic          grey;
        sector_t       sect;
    } pixel_t;

    pixel_t predicted_pixels[$];

    initial
    begin
        errors         = 0;
        outstanding    = 0;
        pixels_checked = 0;
        grey_pixels    = 0;
        sectors_hit    = '0;
    end

    // Clamp a signed fixed-point level to 0..ONE
    function automatic logic [FB:0] clamp_level(input logic signed [SAT_W-1:0] x);
        if (x <= 0)
            return '0;
        else if (64'(x) >= ONE)
            return ONE[FB:0];
        else
            return x[FB:0];
    endfunction

    // Fixed-point product, truncated to FB fraction bits
    function automatic logic [63:0] scale(input logic [63:0] a, input logic [63:0] b);
        return (a * b) >> FB;
    endfunction

    // Hexcone HSV to RGB for one pixel
    function automatic pixel_t convert_pixel(input logic [HUE_W-1:0] h_raw,
                                             input logic signed [SAT_W-1:0] s_raw,
                                             input logic signed [BRIGHT_W-1:0] v_raw);
        pixel_t      px;
        logic [63:0] h6;
        logic [63:0] frac;
        logic [63:0] low_t;
        logic [63:0] fall_t;
        logic [63:0] rise_t;
        logic [63:0] full_t;
        px        = '0;
        px.hue    = h_raw[FB-1:0];
        px.sat    = clamp_level(s_raw);
        px.bright = clamp_level(v_raw);
        full_t    = 64'(px.bright);
        if (px.sat == 0)
        begin
            px.grey  = 1'b1;
            px.red   = px.bright;
            px.green = px.bright;
            px.blue  = px.bright;
        end
        else
        begin
            h6      = 64'(px.hue) * 64'd6;
            px.sect = sector_t'(h6[FB+SECTOR_W-1:FB]);
            frac    = h6 & (ONE - 64'd1);
            low_t   = scale(full_t, ONE - 64'(px.sat));
            fall_t  = scale(full_t, ONE - scale(64'(px.sat), frac));
            rise_t  = scale(full_t, ONE - scale(64'(px.sat), ONE - frac));
            case (px.sect)
                SECT_RED_YELLOW:
                begin
                    px.red = full_t[FB:0]; px.green = rise_t[FB:0]; px.blue = low_t[FB:0];
                end
                SECT_YELLOW_GREEN:
                begin
                    px.red = fall_t[FB:0]; px.green = full_t[FB:0]; px.blue = low_t[FB:0];
                end
                SECT_GREEN_CYAN:
                begin
                    px.red = low_t[FB:0]; px.green = full_t[FB:0]; px.blue = rise_t[FB:0];
                end
                SECT_CYAN_BLUE:
                begin
                    px.red = low_t[FB:0]; px.green = fall_t[FB:0]; px.blue = full_t[FB:0];
                end
                SECT_BLUE_MAGENTA:
                begin
                    px.red = rise_t[FB:0]; px.green = low_t[FB:0]; px.blue = full_t[FB:0];
                end
                default:
                begin
                    px.red = full_t[FB:0]; px.green = low_t[FB:0]; px.blue = fall_t[FB:0];
                end
            endcase
        end
        return px;
    endfunction

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [FB:0] want,
                                   input logic [FB:0] got);
        $display("[%0t] mismatch on %s for pixel %0d: expected %0d, got %0d",
                 $realtime, what, pixels_checked, want, got);
        errors++;
    endtask

    task automatic check_field(input string what, input logic [FB:0] want,
                               input logic [FB:0] got);
        if (want !== got)
            report_mismatch(what, want, got);
    endtask

    // Compare results first, then queue the prediction for a new request
    always @(posedge clk)
    begin
        pixel_t px;
        if (rst_n)
        begin
            if (done)
            begin
                if (predicted_pixels.size() == 0)
                    report_mismatch("result with no request waiting", '0, red);
                else
                begin
                    px = predicted_pixels.pop_front();
                    check_field("red", px.red, red);
                    check_field("green", px.green, green);
                    check_field("blue", px.blue, blue);
                    check_field("hue_wrapped", {1'b0, px.hue}, {1'b0, hue_wrapped});
                    check_field("sat_clamped", px.sat, sat_clamped);
                    check_field("bright_clamped", px.bright, bright_clamped);
                    pixels_checked++;
                end
            end
            if (start && !busy)
            begin
                px = convert_pixel(hue_in, sat_in, bright_in);
                predicted_pixels.push_back(px);
                if (px.grey)
                    grey_pixels++;
                else
                    sectors_hit[px.sect] = 1'b1;
            end
            outstanding = predicted_pixels.size();
        end
    end

endmodule

// ===== tb/sv/tb_hsv_to_rgb_converter_unit.sv =====
module tb_hsv_to_rgb_converter_unit;
    import hsvrgb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB         = FRAC_BITS_DEF;
    localparam int N_RANDOM   = 400;
    localparam int IDLE_LIMIT = 500;
    localparam int DRAIN_WAIT = 8;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic signed [HUE_W-1:0]    hue_in;
    logic signed [SAT_W-1:0]    sat_in;
    logic signed [BRIGHT_W-1:0] bright_in;
    logic                       done;
    logic [FB:0]                red;
    logic [FB:0]                green;
    logic [FB:0]                blue;
    logic [FB-1:0]              hue_wrapped;
    logic [FB:0]                sat_clamped;
    logic [FB:0]                bright_clamped;

    int         errors;
    int         outstanding;
    int         pixels_checked;
    int         grey_pixels;
    logic [5:0] sectors_hit;
    int         n_directed;
    int         idle_cycles;

    hsv_to_rgb_converter_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .hue_in         (hue_in),
        .sat_in         (sat_in),
        .bright_in      (bright_in),
        .done           (done),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .hue_wrapped    (hue_wrapped),
        .sat_clamped    (sat_clamped),
        .bright_clamped (bright_clamped)
    );

    hsv_to_rgb_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .hue_in         (hue_in),
        .sat_in         (sat_in),
        .bright_in      (bright_in),
        .done           (done),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .hue_wrapped    (hue_wrapped),
        .sat_clamped    (sat_clamped),
        .bright_clamped (bright_clamped),
        .errors         (errors),
        .outstanding    (outstanding),
        .pixels_checked (pixels_checked),
        .grey_pixels    (grey_pixels),
        .sectors_hit    (sectors_hit)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive one request at the falling edge and hold it until accepted
    task automatic send_pixel(input int h, input int s, input int v);
        start     <= 1'b1;
        hue_in    <= h[HUE_W-1:0];
        sat_in    <= s[SAT_W-1:0];
        bright_in <= v[BRIGHT_W-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop start for a number of cycles, with junk on the fields
    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            start     <= 1'b0;
            hue_in    <= HUE_W'($urandom);
            sat_in    <= SAT_W'($urandom);
            bright_in <= BRIGHT_W'($urandom);
            repeat (cycles) @(negedge clk);
        end
    endtask

    // Mostly in-range levels, with extremes, zero and raw noise mixed in
    function automatic int rand_level();
        int picks[7] = '{-131072, 131071, 0, 65536, 65535, 1, -1};
        case ($urandom_range(0, 9))
            0:       return int'($urandom);
            1:       return picks[$urandom_range(0, 6)];
            2:       return 0;
            default: return int'($urandom_range(0, 65536));
        endcase
    endfunction

    // End the run if no request is accepted and no result returns for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no request or result for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int h;
        int gap;
        rst_n     = 1'b0;
        start     = 1'b0;
        hue_in    = '0;
        sat_in    = '0;
        bright_in = '0;
        n_directed = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Hue extremes, exact turn and negative hue wrap
        send_pixel(-8388608, 65536, 65536);
        send_pixel(8388607, 65536, 65536);
        idle_gap(1);
        send_pixel(0, 65536, 65536);
        send_pixel(65536, 65536, 65536);
        send_pixel(-16384, 65536, 65536);
        idle_gap(2);
        // One pixel in the middle of each sector
        send_pixel(5461, 40000, 50000);
        send_pixel(16384, 40000, 50000);
        send_pixel(27307, 40000, 50000);
        idle_gap(1);
        send_pixel(38229, 40000, 50000);
        send_pixel(49152, 40000, 50000);
        send_pixel(60075, 40000, 50000);
        // Either side of the first sector boundary
        send_pixel(10922, 65536, 65536);
        send_pixel(10923, 65536, 65536);
        idle_gap(3);
        // Saturation clamping and grey
        send_pixel(20000, -131072, 65536);
        send_pixel(20000, 131071, 65536);
        send_pixel(20000, 0, 40000);
        send_pixel(20000, -1, 30000);
        send_pixel(20000, 65535, 65536);
        idle_gap(1);
        // Brightness clamping and the smallest levels
        send_pixel(30000, 65536, -131072);
        send_pixel(30000, 65536, 131071);
        send_pixel(30000, 32768, 0);
        send_pixel(30000, 32768, 1);
        n_directed = 22;

        // Random pixels: some back-to-back stretches, otherwise random gaps
        for (int i = 0; i < N_RANDOM; i++)
        begin
            case ($urandom_range(0, 5))
                0:       h = int'($urandom);
                1:       h = 10923 * $urandom_range(0, 6) + $urandom_range(0, 4) - 2
                             + 65536 * ($urandom_range(0, 255) - 128);
                default: h = $urandom_range(0, 65535);
            endcase
            send_pixel(h, rand_level(), rand_level());
            if ((i % 100) < 30)
                gap = 0;
            else
            begin
                gap = $urandom_range(0, 99);
                if (gap < 55)
                    gap = 0;
                else if (gap < 90)
                    gap = $urandom_range(1, 3);
                else
                    gap = $urandom_range(8, 40);
            end
            idle_gap(gap);
        end
        start <= 1'b0;

        // Drain the pipeline, then hold a little longer for stray results
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("Checked %0d pixels (%0d directed, %0d random) with gaps and back-to-back runs.",
                 pixels_checked, n_directed, N_RANDOM);
        $display("Sectors reached: %b, grey pixels: %0d, mismatches: %0d.",
                 sectors_hit, grey_pixels, errors);
        if (errors == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
